// File: sv/lppd_pkg.sv
package lppd_pkg;

  // frame layout: byte positions counted from the start byte (= 0)
  localparam int unsigned PosW       = 9;
  localparam logic [PosW-1:0] PosType   = 9'd1;
  localparam logic [PosW-1:0] PosCmd    = 9'd2;
  localparam logic [PosW-1:0] PosLen    = 9'd3;
  localparam logic [PosW-1:0] PosData0  = 9'd4;
  localparam logic [PosW-1:0] PosCsumHi = 9'd5;
  // longest frame: length 255 puts the high checksum byte at 260
  localparam logic [PosW-1:0] PosMax    = 9'd260;

  localparam logic [7:0] StartByteRst = 8'd170;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_FRAME   = 1'b1
  } kind_e;

  // result word data, last field in the lowest bits
  typedef struct packed {
    logic [15:0] frame_checksum;
    logic [7:0]  frame_length;
    logic [7:0]  frame_command;
    logic [7:0]  frame_type;
    logic [7:0]  payload_index;
    logic [7:0]  payload_byte;
  } result_data_t;

  typedef struct packed {
    kind_e        kind;
    result_data_t data;
  } result_t;

endpackage

// File: sv/length_prefixed_packet_deframer_unit.sv
// Length-prefixed packet deframer.
//
// Input stream (s_axis_*): one received byte per word in tdata[7:0]. While
// idle, every byte other than the configured start byte is dropped. A frame
// is start, type, command, length L, L payload bytes, checksum low, checksum
// high. Each payload byte gives one output word (tuser = 0) with its index;
// the high checksum byte gives one frame word (tuser = 1) with the header
// and the 16-bit checksum. The checksum is forwarded, not checked.
// Output stream (m_axis_*): registered, through the skid register while the
// output word is held. Throughput is one byte per cycle while s_axis_tready
// is high, with a combinational position update before the result register.
// A two-entry output stage (output register plus skid register) keeps
// s_axis_tready high while one result waits; a stalled receiver drops
// tready only once both entries are full.
// cfg_we_i/cfg_wdata_i write the start byte; write it only while idle.
// Reset: idle, position 0, start byte 170, output stage empty.
module length_prefixed_packet_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: start byte
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_type,
  // [31:24] frame_command, [39:32] frame_length, [55:40] frame_checksum
  output logic [55:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser    // [0] kind
);
  import lppd_pkg::*;

  logic [7:0]      start_byte_q;
  logic            receiving_q, receiving_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      hdr_type_q, hdr_type_d;
  logic [7:0]      hdr_cmd_q, hdr_cmd_d;
  logic [7:0]      hdr_len_q, hdr_len_d;
  logic [7:0]      csum_lo_q, csum_lo_d;

  logic            res_valid;
  result_t         res;
  logic            in_fire;

  result_t         out_q, skid_q;
  logic            out_valid_q, skid_valid_q;

  logic [PosW-1:0] csum_lo_pos;
  logic [PosW-1:0] csum_hi_pos;
  logic [PosW-1:0] pos_inc;

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign csum_lo_pos = {1'b0, hdr_len_q} + PosData0;
  assign csum_hi_pos = {1'b0, hdr_len_q} + PosCsumHi;
  assign pos_inc     = pos_q + 9'd1;

  // frame parser: next state and result for the byte on the input
  always_comb begin
    receiving_d = receiving_q;
    pos_d       = pos_q;
    hdr_type_d  = hdr_type_q;
    hdr_cmd_d   = hdr_cmd_q;
    hdr_len_d   = hdr_len_q;
    csum_lo_d   = csum_lo_q;
    res_valid   = 1'b0;
    res         = '0;
    res.kind    = KIND_PAYLOAD;
    if (!receiving_q) begin
      if (s_axis_tdata == start_byte_q) begin
        receiving_d = 1'b1;
        pos_d       = PosType;
      end
    end else begin
      pos_d = pos_inc;
      priority if (pos_q == PosType) begin
        hdr_type_d = s_axis_tdata;
      end else if (pos_q == PosCmd) begin
        hdr_cmd_d = s_axis_tdata;
      end else if (pos_q == PosLen) begin
        hdr_len_d = s_axis_tdata;
      end else if (pos_q == csum_lo_pos) begin
        csum_lo_d = s_axis_tdata;
      end else if (pos_q == csum_hi_pos) begin
        res_valid                = 1'b1;
        res.kind                 = KIND_FRAME;
        res.data.frame_type      = hdr_type_q;
        res.data.frame_command   = hdr_cmd_q;
        res.data.frame_length    = hdr_len_q;
        res.data.frame_checksum  = {s_axis_tdata, csum_lo_q};
        receiving_d              = 1'b0;
        pos_d                    = '0;
      end else begin
        // payload byte
        res_valid                = 1'b1;
        res.data.payload_byte    = s_axis_tdata;
        res.data.payload_index   = 8'(pos_q - PosData0);
      end
    end
  end

  // parser state and config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
      receiving_q  <= 1'b0;
      pos_q        <= '0;
      hdr_type_q   <= '0;
      hdr_cmd_q    <= '0;
      hdr_len_q    <= '0;
      csum_lo_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        start_byte_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        receiving_q <= receiving_d;
        pos_q       <= pos_d;
        hdr_type_q  <= hdr_type_d;
        hdr_cmd_q   <= hdr_cmd_d;
        hdr_len_q   <= hdr_len_d;
        csum_lo_q   <= csum_lo_d;
      end
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !m_axis_tready) begin
      if (in_fire && res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_fire && res_valid;
    end
  end

  // payload of the output stage
  always_ff @(posedge clk_i) begin
    if (out_valid_q && !m_axis_tready) begin
      if (in_fire && res_valid) begin
        skid_q <= res;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_q.data;
  assign m_axis_tuser[0] = out_q.kind;

  // skid entry only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // idle parser always sits at position zero
  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !receiving_q |-> (pos_q == '0))
    else $error("position nonzero while idle");

  // position never runs past the longest frame
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax)
    else $error("position beyond longest frame");

  // a frame word always ends the frame
  a_frame_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_valid && (res.kind == KIND_FRAME)) |=> !receiving_q)
    else $error("frame word without return to idle");

endmodule
